/* rtl/dol_pkg.sv */
// ----------------------------------------------------------------------------
// dol_pkg
// Shared types and constants for the depth order list: operation codes,
// controller states and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dol_pkg;

  // default build size and fixed field widths
  localparam int DefMaxItems = 256;
  localparam int IdW         = 8;
  localparam int SizeW       = 9;
  localparam int OpW         = 3;

  // operation codes
  localparam logic [OpW-1:0] OpBack    = 3'd0;
  localparam logic [OpW-1:0] OpFront   = 3'd1;
  localparam logic [OpW-1:0] OpToFront = 3'd2;
  localparam logic [OpW-1:0] OpToBack  = 3'd3;
  localparam logic [OpW-1:0] OpQuery   = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StUpdate
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic cfg_write;
  } dp_cmd_t;

endpackage

/* rtl/dol_ctrl.sv */
// ----------------------------------------------------------------------------
// dol_ctrl
// Sequencer for the depth order list: takes a request, runs the lookup and
// update steps and owns the handshakes on both streams and the config port.
// ----------------------------------------------------------------------------
module dol_ctrl import dol_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cfg_ready_o = 1'b1;
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLookup;
        end
      end
      StLookup: begin
        // search repeats harmlessly while the output slot is still full
        cmd_o.lookup = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/dol_dpath.sv */
// ----------------------------------------------------------------------------
// dol_dpath
// Datapath of the depth order list: a row of cells, one per depth, each
// holding the id at that depth. A match tree finds an id's depth and the id
// at a depth; a move shifts the cells between old and new depth by one.
// ----------------------------------------------------------------------------
module dol_dpath import dol_pkg::*; #(
  parameter int MaxItems = DefMaxItems
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [OpW-1:0]   op_i,
  input  logic [IdW-1:0]   item_i,
  input  logic [IdW-1:0]   dist_i,
  input  logic [IdW-1:0]   qd_i,
  input  logic [SizeW-1:0] cfg_data_i,
  output logic [IdW-1:0]   result_id_o,
  output logic [IdW-1:0]   result_depth_o,
  output logic             range_error_o
);

  // number of cells: ids are 8 bits, so never more than 256
  localparam int Cap = (MaxItems < 256) ? MaxItems : 256;

  logic [IdW-1:0]   cell_q [Cap];
  logic [SizeW-1:0] n_q;
  logic [OpW-1:0]   op_q;
  logic [IdW-1:0]   item_q, dist_q, qd_q;
  logic [IdW-1:0]   dep_q, qid_q;
  logic [IdW-1:0]   dep_w, qid_w;
  logic [IdW-1:0]   nm1;
  logic [SizeW-1:0] sum;
  logic [IdW-1:0]   to_w;
  logic             is_move, err_w, apply, go_back, go_front;
  logic [IdW-1:0]   rid_q, rdep_q;
  logic             rerr_q;

  // list size: zero taken as one, larger values saturated on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= SizeW'(Cap);
    end else if (cmd_i.cfg_write) begin
      if (cfg_data_i == '0) begin
        n_q <= SizeW'(1);
      end else if (cfg_data_i > SizeW'(Cap)) begin
        n_q <= SizeW'(Cap);
      end else begin
        n_q <= cfg_data_i;
      end
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      item_q <= item_i;
      dist_q <= dist_i;
      qd_q   <= qd_i;
    end
  end

  // match trees over the cells: depth of the item, id at the queried depth
  always_comb begin
    dep_w = '0;
    qid_w = '0;
    for (int k = 0; k < Cap; k++) begin
      if (cell_q[k] == item_q) dep_w = dep_w | IdW'(k);
      if (IdW'(k) == qd_q)     qid_w = qid_w | cell_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      dep_q <= dep_w;
      qid_q <= qid_w;
    end
  end

  // target depth and range check
  assign nm1     = IdW'(n_q - SizeW'(1));
  assign sum     = {1'b0, dep_q} + {1'b0, dist_q};
  assign is_move = (op_q <= OpToBack);

  always_comb begin
    case (op_q)
      OpBack:    to_w = (sum > {1'b0, nm1}) ? nm1 : sum[IdW-1:0];
      OpFront:   to_w = (dist_q >= dep_q) ? '0 : dep_q - dist_q;
      OpToFront: to_w = '0;
      OpToBack:  to_w = nm1;
      default:   to_w = dep_q;
    endcase
  end

  always_comb begin
    case (op_q)
      OpBack, OpFront, OpToFront, OpToBack: err_w = ({1'b0, item_q} >= n_q);
      OpQuery:                              err_w = ({1'b0, qd_q} >= n_q);
      default:                              err_w = 1'b0;
    endcase
  end

  assign apply    = cmd_i.update && is_move && !err_w;
  assign go_back  = to_w > dep_q;
  assign go_front = to_w < dep_q;

  // cells: identity on reset and on size write, shift by one on a move
  for (genvar k = 0; k < Cap; k++) begin : g_cell
    localparam logic [IdW-1:0] K = IdW'(k);
    logic [IdW-1:0] up_w, dn_w;

    if (k < Cap - 1) begin : g_up
      assign up_w = cell_q[k+1];
    end else begin : g_up_end
      assign up_w = cell_q[k];
    end
    if (k > 0) begin : g_dn
      assign dn_w = cell_q[k-1];
    end else begin : g_dn_end
      assign dn_w = cell_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cell_q[k] <= K;
      end else if (cmd_i.cfg_write) begin
        cell_q[k] <= K;
      end else if (apply) begin
        if (K == to_w) begin
          cell_q[k] <= item_q;
        end else if (go_back && K >= dep_q && K < to_w) begin
          cell_q[k] <= up_w;
        end else if (go_front && K > to_w && K <= dep_q) begin
          cell_q[k] <= dn_w;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rerr_q <= err_w;
      if (err_w) begin
        rid_q  <= '0;
        rdep_q <= '0;
      end else if (is_move) begin
        rid_q  <= item_q;
        rdep_q <= to_w;
      end else if (op_q == OpQuery) begin
        rid_q  <= qid_q;
        rdep_q <= qd_q;
      end else begin
        rid_q  <= '0;
        rdep_q <= '0;
      end
    end
  end

  assign result_id_o    = rid_q;
  assign result_depth_o = rdep_q;
  assign range_error_o  = rerr_q;

endmodule

/* rtl/depth_order_list.sv */
// ----------------------------------------------------------------------------
// depth_order_list
// Keeps a stacking order of item ids over depths and moves or reads items.
// ----------------------------------------------------------------------------
// Each request is accepted and latched, then the match search runs across the
// depth cells, and a last step shifts the cells and registers the result. A new
// request is taken once the previous one has reached the output register. If a
// result waits unread, the next request is held after its search. Every request
// gives one result.
// Writing the size register returns the order to identity; it must only be
// written while no request is in flight. Storage is one cell per depth, the
// smaller of MAX_ITEMS and 256.
module depth_order_list import dol_pkg::*; #(
  parameter int MAX_ITEMS = DefMaxItems
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // item_id, distance, query_depth
  input  logic [OpW-1:0]   s_axis_tuser,   // operation
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // result_id, result_depth
  output logic             m_axis_tuser,   // range_error
  // size register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  dp_cmd_t        cmd;
  logic [IdW-1:0] result_id, result_depth;

  // sequencer
  dol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // cells and result path
  dol_dpath #(
    .MaxItems (MAX_ITEMS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (s_axis_tuser),
    .item_i         (s_axis_tdata[7:0]),
    .dist_i         (s_axis_tdata[15:8]),
    .qd_i           (s_axis_tdata[23:16]),
    .cfg_data_i     (cfg_data_i),
    .result_id_o    (result_id),
    .result_depth_o (result_depth),
    .range_error_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {result_depth, result_id};

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the depth order list. Requests go in on the slave
// stream; a local copy of the stacking order predicts each result, and a
// scoreboard compares the result stream field by field, in order. The size
// register is rewritten between phases, so each phase starts from identity.
// ----------------------------------------------------------------------------
module tb_top;
  import dol_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // spare operation codes, which must leave the order alone
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  // cycles allowed after the last result for the block to settle
  localparam int SettleCycles = 6;
  // length of the receiver hold-off in the back-pressure test
  localparam int HoldOffCycles = 150;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [IdW-1:0] depth;
    logic           err;
  } order_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;   // item_id, distance, query_depth
  logic [OpW-1:0]   s_axis_tuser = '0;   // operation
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;        // result_id, result_depth
  logic             m_axis_tuser;        // range_error
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i = '0;

  // local copy of the order and the size register
  logic [IdW-1:0]   order_id_at [DefMaxItems];
  logic [IdW-1:0]   order_depth_of [DefMaxItems];
  logic [SizeW-1:0] order_size;

  order_result_t    pending_results[$];
  int               fail_count = 0;
  int               request_gap_pct = 0;
  int               result_stall_pct = 0;
  logic             hold_off_req = 1'b0;
  int               hold_off_left = 0;

  depth_order_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // order back to identity
  task automatic reset_local_order();
    for (int i = 0; i < DefMaxItems; i++) begin
      order_id_at[i]    = IdW'(i);
      order_depth_of[i] = IdW'(i);
    end
  endtask

  // size in use: zero acts as one, large values saturate
  function automatic int active_size();
    if (order_size == '0) return 1;
    if (int'(order_size) > DefMaxItems) return DefMaxItems;
    return int'(order_size);
  endfunction

  // apply one request to the local order and return its result
  function automatic order_result_t predict_order_op(input logic [OpW-1:0] op,
                                                     input logic [IdW-1:0] id,
                                                     input logic [IdW-1:0] distance,
                                                     input logic [IdW-1:0] qd);
    order_result_t res;
    int            n;
    int            from;
    int            to;
    logic [IdW-1:0] moved;
    res = '0;
    n   = active_size();
    case (op)
      OpBack, OpFront, OpToFront, OpToBack: begin
        if (int'(id) >= n) begin
          res.err = 1'b1;
        end else begin
          from = int'(order_depth_of[id]);
          case (op)
            OpBack:    to = (from + int'(distance) > n - 1) ? n - 1
                                                              : from + int'(distance);
            OpFront:   to = (int'(distance) >= from) ? 0 : from - int'(distance);
            OpToFront: to = 0;
            default:   to = n - 1;
          endcase
          // items in between slide one depth to close the gap
          for (int k = from; k < to; k++) begin
            moved                 = order_id_at[k + 1];
            order_id_at[k]        = moved;
            order_depth_of[moved] = IdW'(k);
          end
          for (int k = from; k > to; k--) begin
            moved                 = order_id_at[k - 1];
            order_id_at[k]        = moved;
            order_depth_of[moved] = IdW'(k);
          end
          order_id_at[to]    = id;
          order_depth_of[id] = IdW'(to);
          res.id             = id;
          res.depth          = IdW'(to);
        end
      end
      OpQuery: begin
        if (int'(qd) >= n) begin
          res.err = 1'b1;
        end else begin
          res.id    = order_id_at[qd];
          res.depth = qd;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // offer one request and record its expected result on acceptance;
  // tvalid is left high so a following request goes straight on
  task automatic send_order_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                                    input logic [IdW-1:0] distance,
                                    input logic [IdW-1:0] qd);
    while ($urandom_range(0, 99) < request_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {qd, distance, id};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_order_op(op, id, distance, qd));
  endtask

  function automatic logic [OpW-1:0] pick_op(input int sel);
    case (sel)
      0:       return OpBack;
      1:       return OpFront;
      2:       return OpToFront;
      3:       return OpToBack;
      4:       return OpQuery;
      5:       return OpSpare5;
      6:       return OpSpare6;
      default: return OpSpare7;
    endcase
  endfunction

  // random request, mostly in range for the current size
  task automatic send_random_request();
    int             n;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    logic [IdW-1:0] distance;
    logic [IdW-1:0] qd;
    n    = active_size();
    op   = ($urandom_range(0, 9) == 0) ? pick_op($urandom_range(5, 7))
                                       : pick_op($urandom_range(0, 4));
    id   = ($urandom_range(0, 99) < 85) ? IdW'($urandom_range(0, n - 1))
                                        : IdW'($urandom_range(0, 255));
    qd   = ($urandom_range(0, 99) < 85) ? IdW'($urandom_range(0, n - 1))
                                        : IdW'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1:          distance = '0;
      2:             distance = '1;
      3, 4, 5, 6:    distance = IdW'($urandom_range(0, (n > 255) ? 255 : n));
      default:       distance = IdW'($urandom_range(0, 255));
    endcase
    send_order_request(op, id, distance, qd);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // size register write; only called once the block is drained
  task automatic write_list_size(input logic [SizeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_size = value;
    reset_local_order();
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return SizeW'($urandom_range(0, 8));
      1:       return SizeW'($urandom_range(9, 40));
      2:       return SizeW'($urandom_range(0, 511));
      default: return SizeW'(DefMaxItems);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // moves and queries at the reset size, field extremes and spare codes
  task automatic test_reset_order();
    send_order_request(OpQuery,   8'd0,   8'd0,   8'd0);
    send_order_request(OpQuery,   8'd0,   8'd0,   8'd255);
    send_order_request(OpBack,    8'd0,   8'd1,   8'd0);
    send_order_request(OpBack,    8'd0,   8'd255, 8'd0);
    send_order_request(OpFront,   8'd0,   8'd0,   8'd0);
    send_order_request(OpBack,    8'd7,   8'd0,   8'd0);
    send_order_request(OpFront,   8'd255, 8'd255, 8'd0);
    send_order_request(OpToFront, 8'd128, 8'd0,   8'd0);
    send_order_request(OpToBack,  8'd1,   8'd0,   8'd0);
    send_order_request(OpToBack,  8'd255, 8'd0,   8'd0);
    send_order_request(OpQuery,   8'd0,   8'd0,   8'd128);
    send_order_request(OpSpare5,  8'd255, 8'd255, 8'd255);
    send_order_request(OpSpare6,  8'd3,   8'd3,   8'd3);
    send_order_request(OpSpare7,  8'd0,   8'd0,   8'd0);
    send_order_request(OpQuery,   8'd0,   8'd0,   8'd0);
    drain_requests();
  endtask

  // smallest sizes, zero size, saturating sizes and range errors
  task automatic test_size_extremes();
    write_list_size(9'd1);
    send_order_request(OpBack,  8'd0,   8'd5,   8'd0);
    send_order_request(OpBack,  8'd1,   8'd0,   8'd0);
    send_order_request(OpQuery, 8'd0,   8'd0,   8'd1);
    drain_requests();
    write_list_size(9'd0);
    send_order_request(OpQuery, 8'd0,   8'd0,   8'd0);
    send_order_request(OpToFront, 8'd255, 8'd0, 8'd0);
    drain_requests();
    write_list_size(9'd2);
    send_order_request(OpToBack, 8'd0,  8'd0,   8'd0);
    send_order_request(OpQuery,  8'd0,  8'd0,   8'd0);
    send_order_request(OpQuery,  8'd0,  8'd0,   8'd2);
    drain_requests();
    write_list_size(9'd511);
    send_order_request(OpQuery,  8'd0,  8'd0,   8'd255);
    drain_requests();
    write_list_size(9'd300);
    send_order_request(OpToFront, 8'd255, 8'd0, 8'd0);
    drain_requests();
  endtask

  // random requests in segments, each at a fresh random size
  task automatic test_random_orders(input int count);
    int sent;
    int seg;
    sent = 0;
    while (sent < count) begin
      drain_requests();
      write_list_size(pick_size());
      seg = $urandom_range(20, 60);
      for (int i = 0; i < seg; i++) send_random_request();
      sent += seg;
    end
    drain_requests();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    write_list_size(9'd24);
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_request();
    drain_requests();
  endtask

  // sender waits for every result mid-stream, then carries on
  task automatic test_drain_pause();
    write_list_size(9'd12);
    for (int i = 0; i < 20; i++) send_random_request();
    drain_requests();
    for (int i = 0; i < 20; i++) send_random_request();
    drain_requests();
  endtask

  // result acceptance, with random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= result_stall_pct);
    end
  end

  // scoreboard: each result against the oldest expectation
  always @(posedge clk_i) begin
    order_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: id %0d depth %0d range_error %0b",
               m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.id) begin
          $error("result_id: expected %0d, got %0d", want.id, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== want.depth) begin
          $error("result_depth: expected %0d, got %0d", want.depth, m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tuser !== want.err) begin
          $error("range_error: expected %0b, got %0b", want.err, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    order_size = SizeW'(DefMaxItems);
    reset_local_order();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender gaps light, receiver stalls heavy
    request_gap_pct  = 22;
    result_stall_pct = 74;
    test_reset_order();
    test_size_extremes();
    test_random_orders(320);

    // sender gaps heavy, receiver stalls light
    request_gap_pct  = 74;
    result_stall_pct = 22;
    test_random_orders(320);

    // no idling on either side
    request_gap_pct  = 0;
    result_stall_pct = 0;
    test_back_pressure();
    test_random_orders(300);
    test_drain_pause();

    repeat (SettleCycles * 4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/dol_pkg.sv
rtl/dol_ctrl.sv
rtl/dol_dpath.sv
rtl/depth_order_list.sv
test/tb_top.sv
